FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ppda_pkg.sv
// Package for the phoretic drift accumulator: widths, register codes, reset values, states.
`default_nettype none

package ppda_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ACC_BITS_DEF   = 40;

    localparam int CUTOFF_W    = 24;
    localparam int STRENGTH_W  = 63;
    localparam int CFG_DATA_W  = 63;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH = 1'd1;

    localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET   = 24'd1342177;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 63'd236118320000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DPROD,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: src/ppda_smul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
`default_nettype none

module ppda_smul #(
    parameter int AW = 24,
    parameter int BW = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            busy,
    output logic [AW+BW-1:0] p
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] a_reg, a_next;
    logic [PW-1:0] p_reg, p_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [AW:0]   sum;

    always_comb
    begin
        // upper half plus multiplicand when the current multiplier bit is set
        sum = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
        a_next    = a_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            p_next    = {{AW{1'b0}}, b};
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next    = {sum, p_reg[BW-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule

`default_nettype wire

FILE: src/ppda_isqrt.sv
// Digit-serial integer square root: two operand bits in, one root bit out per cycle.
`default_nettype none

module ppda_isqrt #(
    parameter int W = 49
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         operand,
    output logic                 busy,
    output logic [(W+1)/2-1:0]   root
);

    localparam int PW  = W + (W % 2);
    localparam int N   = PW / 2;
    localparam int RMW = N + 2;
    localparam int TW  = N + 4;
    localparam int CW  = $clog2(N + 1);

    logic [PW-1:0]  op_reg, op_next;
    logic [N-1:0]   root_reg, root_next;
    logic [RMW-1:0] rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [TW-1:0]  shifted;
    logic [TW-1:0]  trial;
    logic [TW-1:0]  diff;
    logic           fits;

    always_comb
    begin
        shifted = {rem_reg, op_reg[PW-1 -: 2]};
        trial   = TW'({root_reg, 2'b01});
        diff    = shifted - trial;
        fits    = (shifted >= trial);
        op_next   = op_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            op_next   = PW'(operand);
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CW'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next   = {op_reg[PW-3:0], 2'b00};
            root_next = {root_reg[N-2:0], fits};
            rem_next  = fits ? RMW'(diff) : RMW'(shifted);
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: src/ppda_sdiv.sv
// Bit-serial restoring divider with a QW-bit quotient and an overflow flag.
`default_nettype none

module ppda_sdiv #(
    parameter int NW = 87,
    parameter int DW = 74,
    parameter int QW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [QW-1:0] quot,
    output logic          ovf
);

    localparam int HW  = NW - QW;
    localparam int CMW = (HW > DW) ? HW : DW;
    localparam int CW  = $clog2(QW + 1);

    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;   // numerator bits out at the top, quotient in at the bottom
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [HW-1:0] num_hi;
    logic [DW:0]   part;
    logic [DW:0]   den_ext;
    logic          fits;

    always_comb
    begin
        num_hi  = num[NW-1:QW];
        part    = {rem_reg, low_reg[QW-1]};
        den_ext = {1'b0, den_reg};
        fits    = (part >= den_ext);
        den_next  = den_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            // a quotient wider than QW bits shows up as an upper numerator part not below the divisor
            den_next  = den;
            rem_next  = DW'(num_hi);
            low_next  = num[QW-1:0];
            ovf_next  = (CMW'(num_hi) >= CMW'(den));
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DW'(part - den_ext) : part[DW-1:0];
            low_next  = {low_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign quot = low_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

FILE: src/pairwise_phoretic_drift_accumulator.sv
// Top level of the pairwise phoretic drift accumulator.
//
//  channel  dir  handshake          contents
//  s_*      in   s_tvalid/s_tready  one pair: four positions, first and last flags
//  m_*      out  m_tvalid/m_tready  drift sums and clip flag, one beat per last pair
//  cfg_*    in   cfg_we             cutoff radius and strength registers
//
// A pair inside the cutoff runs bit-serial squares, root, d2*r product and quotient,
// one bit per cycle; a pair outside the cutoff runs the squares only.
// One pair at a time; s_tready is high only when the sequencer is idle.
// The result register lets the next pair start while a beat waits on m_tready.
// Reset clears sums, clip flag and control, and loads the register defaults.
`default_nettype none

module pairwise_phoretic_drift_accumulator #(
    parameter int COORD_BITS = ppda_pkg::COORD_BITS_DEF,
    parameter int ACC_BITS   = ppda_pkg::ACC_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * ACC_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppda_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // target_x, target_y, neighbour_x, neighbour_y
    input  logic                             s_tlast,   // last_pair
    input  logic                             s_tuser,   // first_pair
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,   // drift_x, drift_y
    output logic                             m_tuser    // saturated
);

    import ppda_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int AB  = ACC_BITS;
    localparam int D2W = 2 * CB + 1;
    localparam int RW  = CB + 1;
    localparam int NW  = STRENGTH_W + CB;
    localparam int DW  = D2W + RW;
    localparam int C2W = 2 * CUTOFF_W;
    localparam int CMW = (D2W > C2W) ? D2W : C2W;

    localparam logic [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    // term from quotient magnitude: {clip, value}
    function automatic logic [AB:0] make_term(input logic [AB-1:0] q, input logic over,
                                              input logic neg);
        logic          clip;
        logic [AB-1:0] val;
        if (neg)
        begin
            // exactly 2^(AB-1) still fits as the most negative value
            clip = over || (q[AB-1] && (|q[AB-2:0]));
            val  = clip ? ACC_MIN : (~q + AB'(1));
        end
        else
        begin
            clip = over || q[AB-1];
            val  = clip ? ACC_MAX : q;
        end
        return {clip, val};
    endfunction

    // saturating signed add: {clip, value}
    function automatic logic [AB:0] sat_add(input logic [AB-1:0] a, input logic [AB-1:0] b);
        logic [AB:0]   s;
        logic          over;
        logic [AB-1:0] val;
        s    = {a[AB-1], a} + {b[AB-1], b};
        over = (s[AB] != s[AB-1]);
        val  = over ? (s[AB] ? ACC_MIN : ACC_MAX) : s[AB-1:0];
        return {over, val};
    endfunction

    // input unpack
    logic [CB-1:0] tgt_x, tgt_y, nbr_x, nbr_y;
    logic          neg_x_in, neg_y_in;
    logic [CB-1:0] abs_x, abs_y;
    logic          accept;

    // serial unit handshakes and results
    logic               sqx_busy, sqy_busy, cut2_busy, numx_busy, numy_busy;
    logic [2*CB-1:0]    sqx_p, sqy_p;
    logic [C2W-1:0]     cut2_p;
    logic [NW-1:0]      numx_p, numy_p;
    logic               root_start, root_busy;
    logic [RW-1:0]      root;
    logic               dprod_start, dprod_busy;
    logic [DW-1:0]      dprod_p;
    logic               div_start, divx_busy, divy_busy;
    logic [AB-1:0]      qx, qy;
    logic               ovfx, ovfy;

    // datapath
    logic [D2W-1:0] d2;
    logic           in_range;
    logic [AB:0]    term_x, term_y, add_x, add_y;

    state_t                state_reg, state_next;
    logic [CUTOFF_W-1:0]   cutoff_reg, cutoff_next;
    logic [STRENGTH_W-1:0] strength_reg, strength_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    logic                  last_reg, last_next;
    logic [D2W-1:0]        d2_reg, d2_next;
    logic [AB-1:0]         sum_x_reg, sum_x_next;
    logic [AB-1:0]         sum_y_reg, sum_y_next;
    logic                  clip_reg, clip_next;
    logic                  out_valid_reg, out_valid_next;
    logic [AB-1:0]         out_x_reg, out_x_next;
    logic [AB-1:0]         out_y_reg, out_y_next;
    logic                  out_sat_reg, out_sat_next;

    assign tgt_x    = s_tdata[CB-1:0];
    assign tgt_y    = s_tdata[2*CB-1:CB];
    assign nbr_x    = s_tdata[3*CB-1:2*CB];
    assign nbr_y    = s_tdata[4*CB-1:3*CB];
    assign neg_x_in = (nbr_x < tgt_x);
    assign neg_y_in = (nbr_y < tgt_y);
    assign abs_x    = neg_x_in ? (tgt_x - nbr_x) : (nbr_x - tgt_x);
    assign abs_y    = neg_y_in ? (tgt_y - nbr_y) : (nbr_y - tgt_y);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // squares, cutoff square and strength products all start on the accepted beat
    ppda_smul #(.AW(CB), .BW(CB)) u_sqx (
        .clk(clk), .rst_n(rst_n), .start(accept), .a(abs_x), .b(abs_x),
        .busy(sqx_busy), .p(sqx_p)
    );

    ppda_smul #(.AW(CB), .BW(CB)) u_sqy (
        .clk(clk), .rst_n(rst_n), .start(accept), .a(abs_y), .b(abs_y),
        .busy(sqy_busy), .p(sqy_p)
    );

    ppda_smul #(.AW(CUTOFF_W), .BW(CUTOFF_W)) u_cut2 (
        .clk(clk), .rst_n(rst_n), .start(accept), .a(cutoff_reg), .b(cutoff_reg),
        .busy(cut2_busy), .p(cut2_p)
    );

    ppda_smul #(.AW(STRENGTH_W), .BW(CB)) u_numx (
        .clk(clk), .rst_n(rst_n), .start(accept), .a(strength_reg), .b(abs_x),
        .busy(numx_busy), .p(numx_p)
    );

    ppda_smul #(.AW(STRENGTH_W), .BW(CB)) u_numy (
        .clk(clk), .rst_n(rst_n), .start(accept), .a(strength_reg), .b(abs_y),
        .busy(numy_busy), .p(numy_p)
    );

    ppda_isqrt #(.W(D2W)) u_root (
        .clk(clk), .rst_n(rst_n), .start(root_start), .operand(d2),
        .busy(root_busy), .root(root)
    );

    // d^2 * floor(d): one divide by this gives floor(floor(S*a/d2)/r)
    ppda_smul #(.AW(D2W), .BW(RW)) u_dprod (
        .clk(clk), .rst_n(rst_n), .start(dprod_start), .a(d2_reg), .b(root),
        .busy(dprod_busy), .p(dprod_p)
    );

    ppda_sdiv #(.NW(NW), .DW(DW), .QW(AB)) u_divx (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(numx_p), .den(dprod_p),
        .busy(divx_busy), .quot(qx), .ovf(ovfx)
    );

    ppda_sdiv #(.NW(NW), .DW(DW), .QW(AB)) u_divy (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(numy_p), .den(dprod_p),
        .busy(divy_busy), .quot(qy), .ovf(ovfy)
    );

    assign d2       = D2W'(sqx_p) + D2W'(sqy_p);
    // d2 below cutoff^2 already implies each axis is below the cutoff
    assign in_range = (d2 != '0) && (CMW'(d2) < CMW'(cut2_p));
    assign term_x   = make_term(qx, ovfx, neg_x_reg);
    assign term_y   = make_term(qy, ovfy, neg_y_reg);
    assign add_x    = sat_add(sum_x_reg, term_x[AB-1:0]);
    assign add_y    = sat_add(sum_y_reg, term_y[AB-1:0]);

    // register writes
    always_comb
    begin
        cutoff_next   = cutoff_reg;
        strength_next = strength_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUTOFF:   cutoff_next   = cfg_data[CUTOFF_W-1:0];
                REG_STRENGTH: strength_next = cfg_data[STRENGTH_W-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        root_start     = 1'b0;
        dprod_start    = 1'b0;
        div_start      = 1'b0;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        last_next      = last_reg;
        d2_next        = d2_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_sat_next   = out_sat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_x_next = neg_x_in;
                    neg_y_next = neg_y_in;
                    last_next  = s_tlast;
                    if (s_tuser)
                    begin
                        sum_x_next = '0;
                        sum_y_next = '0;
                        clip_next  = 1'b0;
                    end
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (!(sqx_busy || sqy_busy || cut2_busy || numx_busy || numy_busy))
                begin
                    d2_next = d2;
                    if (in_range)
                    begin
                        root_start = 1'b1;
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (!root_busy)
                begin
                    dprod_start = 1'b1;
                    state_next  = ST_DPROD;
                end
            end
            ST_DPROD:
            begin
                if (!dprod_busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!divx_busy && !divy_busy)
                begin
                    sum_x_next = add_x[AB-1:0];
                    sum_y_next = add_y[AB-1:0];
                    clip_next  = clip_reg | term_x[AB] | term_y[AB] | add_x[AB] | add_y[AB];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = sum_x_reg;
                    out_y_next     = sum_y_reg;
                    out_sat_next   = clip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cutoff_reg    <= CUTOFF_RESET;
            strength_reg  <= STRENGTH_RESET;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cutoff_reg    <= cutoff_next;
            strength_reg  <= strength_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        last_reg    <= last_next;
        d2_reg      <= d2_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_sat_reg <= out_sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_y_reg, out_x_reg});
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire

FILE: src/ppda_checker.sv
// Port-level checker for the drift accumulator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module ppda_checker #(
    parameter int OUT_W = ((2 * ppda_pkg::ACC_BITS_DEF + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // a stalled result beat holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed under stall")

    // one pair at a time: busy right after an accepted beat
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "input accepted while a pair is in work")

    // a new result is loaded only from the emit step, never while idle
    `ASSERT_CLK(a_load_from_emit, clk, rst_n, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without a pair in work")

    // no result while reset is held; valid is still unknown before the first reset edge
    `ASSERT_RST(a_reset_quiet, clk, !rst_n |-> (m_tvalid !== 1'b1), "result valid during reset")

endmodule

bind pairwise_phoretic_drift_accumulator ppda_checker #(.OUT_W(OUT_W)) u_ppda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
